/* design/ssp_pkg.sv */
// ----------------------------------------------------------------------------
// ssp_pkg
// Types, constants and the microprogram of the strapdown propagation block.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int AW = 40;
  localparam int PW = 7;

  localparam logic signed [DW-1:0] ONE = 32'sh0001_0000;
  localparam logic [15:0] TS_RESET = 16'd655;

  // operation codes
  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_MULH = 2'd1;
  localparam logic [1:0] OP_REG  = 2'd2;
  localparam logic [1:0] OP_REG2 = 2'd3;

  // operand addresses, bit 5 selects the scratch memory
  localparam logic [5:0] A_AX0 = 6'd0;
  localparam logic [5:0] A_AX1 = 6'd1;
  localparam logic [5:0] A_AX2 = 6'd2;
  localparam logic [5:0] A_RX0 = 6'd3;
  localparam logic [5:0] A_RX1 = 6'd4;
  localparam logic [5:0] A_RX2 = 6'd5;
  localparam logic [5:0] A_DT  = 6'd6;
  localparam logic [5:0] A_P0  = 6'd7;
  localparam logic [5:0] A_P1  = 6'd8;
  localparam logic [5:0] A_P2  = 6'd9;
  localparam logic [5:0] A_V0  = 6'd10;
  localparam logic [5:0] A_V1  = 6'd11;
  localparam logic [5:0] A_V2  = 6'd12;
  localparam logic [5:0] A_QW  = 6'd13;
  localparam logic [5:0] A_QX  = 6'd14;
  localparam logic [5:0] A_QY  = 6'd15;
  localparam logic [5:0] A_QZ  = 6'd16;
  localparam logic [5:0] A_ONE = 6'd17;
  localparam logic [5:0] T_H0  = 6'd32;
  localparam logic [5:0] T_H1  = 6'd33;
  localparam logic [5:0] T_H2  = 6'd34;
  localparam logic [5:0] T_D2  = 6'd35;
  localparam logic [5:0] T_XX  = 6'd36;
  localparam logic [5:0] T_YY  = 6'd37;
  localparam logic [5:0] T_ZZ  = 6'd38;
  localparam logic [5:0] T_XY  = 6'd39;
  localparam logic [5:0] T_XZ  = 6'd40;
  localparam logic [5:0] T_YZ  = 6'd41;
  localparam logic [5:0] T_XW  = 6'd42;
  localparam logic [5:0] T_YW  = 6'd43;
  localparam logic [5:0] T_ZW  = 6'd44;
  localparam logic [5:0] T_R00 = 6'd45;
  localparam logic [5:0] T_R01 = 6'd46;
  localparam logic [5:0] T_R02 = 6'd47;
  localparam logic [5:0] T_R10 = 6'd48;
  localparam logic [5:0] T_R11 = 6'd49;
  localparam logic [5:0] T_R12 = 6'd50;
  localparam logic [5:0] T_R20 = 6'd51;
  localparam logic [5:0] T_R21 = 6'd52;
  localparam logic [5:0] T_R22 = 6'd53;
  localparam logic [5:0] T_A0  = 6'd54;
  localparam logic [5:0] T_A1  = 6'd55;
  localparam logic [5:0] T_A2  = 6'd56;
  localparam logic [5:0] T_NW  = 6'd57;
  localparam logic [5:0] T_NX  = 6'd58;
  localparam logic [5:0] T_NY  = 6'd59;
  localparam logic [5:0] T_NZ  = 6'd60;

  localparam logic [PW-1:0] PC_LAST = 7'd77;

  typedef struct packed {
    logic       en;
    logic [1:0] op;
    logic [5:0] a;
    logic [5:0] b;
    logic       clr;
    logic       neg;
    logic       wr;
    logic [5:0] dst;
  } instr_t;

  typedef struct packed {
    logic   load;
    instr_t ins;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } sts_t;

  function automatic instr_t mi(logic [1:0] op, logic [5:0] a, logic [5:0] b,
                                int clr, int neg, int wr, logic [5:0] dst);
    instr_t r;
    r.en = 1'b1; r.op = op; r.a = a; r.b = b;
    r.clr = clr[0]; r.neg = neg[0]; r.wr = wr[0]; r.dst = dst;
    return r;
  endfunction

  // accumulate chains; each entry reads a temporary only after the write of it has landed
  function automatic instr_t prog(logic [PW-1:0] pc);
    instr_t r;
    r = '0;
    case (pc)
      7'd0:  r = mi(OP_MULH, A_RX0, A_DT, 1, 0, 1, T_H0);
      7'd1:  r = mi(OP_MULH, A_RX1, A_DT, 1, 0, 1, T_H1);
      7'd2:  r = mi(OP_MULH, A_RX2, A_DT, 1, 0, 1, T_H2);
      7'd3:  r = mi(OP_MULH, A_DT, A_DT, 1, 0, 1, T_D2);
      7'd4:  r = mi(OP_MUL, A_QX, A_QX, 1, 0, 1, T_XX);
      7'd5:  r = mi(OP_MUL, A_QY, A_QY, 1, 0, 1, T_YY);
      7'd6:  r = mi(OP_MUL, A_QZ, A_QZ, 1, 0, 1, T_ZZ);
      7'd7:  r = mi(OP_MUL, A_QX, A_QY, 1, 0, 1, T_XY);
      7'd8:  r = mi(OP_MUL, A_QX, A_QZ, 1, 0, 1, T_XZ);
      7'd9:  r = mi(OP_MUL, A_QY, A_QZ, 1, 0, 1, T_YZ);
      7'd10: r = mi(OP_MUL, A_QX, A_QW, 1, 0, 1, T_XW);
      7'd11: r = mi(OP_MUL, A_QY, A_QW, 1, 0, 1, T_YW);
      7'd12: r = mi(OP_MUL, A_QZ, A_QW, 1, 0, 1, T_ZW);
      7'd13: r = mi(OP_REG,  A_ONE, A_ONE, 1, 0, 0, T_R00);
      7'd14: r = mi(OP_REG2, T_YY, T_YY, 0, 1, 0, T_R00);
      7'd15: r = mi(OP_REG2, T_ZZ, T_ZZ, 0, 1, 1, T_R00);
      7'd16: r = mi(OP_REG2, T_XY, T_XY, 1, 0, 0, T_R01);
      7'd17: r = mi(OP_REG2, T_ZW, T_ZW, 0, 1, 1, T_R01);
      7'd18: r = mi(OP_REG2, T_XZ, T_XZ, 1, 0, 0, T_R02);
      7'd19: r = mi(OP_REG2, T_YW, T_YW, 0, 0, 1, T_R02);
      7'd20: r = mi(OP_REG2, T_XY, T_XY, 1, 0, 0, T_R10);
      7'd21: r = mi(OP_REG2, T_ZW, T_ZW, 0, 0, 1, T_R10);
      7'd22: r = mi(OP_REG,  A_ONE, A_ONE, 1, 0, 0, T_R11);
      7'd23: r = mi(OP_REG2, T_XX, T_XX, 0, 1, 0, T_R11);
      7'd24: r = mi(OP_REG2, T_ZZ, T_ZZ, 0, 1, 1, T_R11);
      7'd25: r = mi(OP_REG2, T_YZ, T_YZ, 1, 0, 0, T_R12);
      7'd26: r = mi(OP_REG2, T_XW, T_XW, 0, 1, 1, T_R12);
      7'd27: r = mi(OP_REG2, T_XZ, T_XZ, 1, 0, 0, T_R20);
      7'd28: r = mi(OP_REG2, T_YW, T_YW, 0, 1, 1, T_R20);
      7'd29: r = mi(OP_REG2, T_YZ, T_YZ, 1, 0, 0, T_R21);
      7'd30: r = mi(OP_REG2, T_XW, T_XW, 0, 0, 1, T_R21);
      7'd31: r = mi(OP_REG,  A_ONE, A_ONE, 1, 0, 0, T_R22);
      7'd32: r = mi(OP_REG2, T_XX, T_XX, 0, 1, 0, T_R22);
      7'd33: r = mi(OP_REG2, T_YY, T_YY, 0, 1, 1, T_R22);
      7'd34: r = mi(OP_MUL, T_R00, A_AX0, 1, 0, 0, T_A0);
      7'd35: r = mi(OP_MUL, T_R01, A_AX1, 0, 0, 0, T_A0);
      7'd36: r = mi(OP_MUL, T_R02, A_AX2, 0, 0, 1, T_A0);
      7'd37: r = mi(OP_MUL, T_R10, A_AX0, 1, 0, 0, T_A1);
      7'd38: r = mi(OP_MUL, T_R11, A_AX1, 0, 0, 0, T_A1);
      7'd39: r = mi(OP_MUL, T_R12, A_AX2, 0, 0, 1, T_A1);
      7'd40: r = mi(OP_MUL, T_R20, A_AX0, 1, 0, 0, T_A2);
      7'd41: r = mi(OP_MUL, T_R21, A_AX1, 0, 0, 0, T_A2);
      7'd42: r = mi(OP_MUL, T_R22, A_AX2, 0, 0, 1, T_A2);
      7'd43: r = mi(OP_REG, A_P0, A_P0, 1, 0, 0, A_P0);
      7'd44: r = mi(OP_MUL, A_V0, A_DT, 0, 0, 0, A_P0);
      7'd45: r = mi(OP_MUL, T_A0, T_D2, 0, 0, 1, A_P0);
      7'd46: r = mi(OP_REG, A_V0, A_V0, 1, 0, 0, A_V0);
      7'd47: r = mi(OP_MUL, T_A0, A_DT, 0, 0, 1, A_V0);
      7'd48: r = mi(OP_REG, A_P1, A_P1, 1, 0, 0, A_P1);
      7'd49: r = mi(OP_MUL, A_V1, A_DT, 0, 0, 0, A_P1);
      7'd50: r = mi(OP_MUL, T_A1, T_D2, 0, 0, 1, A_P1);
      7'd51: r = mi(OP_REG, A_V1, A_V1, 1, 0, 0, A_V1);
      7'd52: r = mi(OP_MUL, T_A1, A_DT, 0, 0, 1, A_V1);
      7'd53: r = mi(OP_REG, A_P2, A_P2, 1, 0, 0, A_P2);
      7'd54: r = mi(OP_MUL, A_V2, A_DT, 0, 0, 0, A_P2);
      7'd55: r = mi(OP_MUL, T_A2, T_D2, 0, 0, 1, A_P2);
      7'd56: r = mi(OP_REG, A_V2, A_V2, 1, 0, 0, A_V2);
      7'd57: r = mi(OP_MUL, T_A2, A_DT, 0, 0, 1, A_V2);
      7'd58: r = mi(OP_REG, A_QW, A_QW, 1, 0, 0, T_NW);
      7'd59: r = mi(OP_MUL, T_H0, A_QX, 0, 1, 0, T_NW);
      7'd60: r = mi(OP_MUL, T_H1, A_QY, 0, 1, 0, T_NW);
      7'd61: r = mi(OP_MUL, T_H2, A_QZ, 0, 1, 1, T_NW);
      7'd62: r = mi(OP_REG, A_QX, A_QX, 1, 0, 0, T_NX);
      7'd63: r = mi(OP_MUL, T_H0, A_QW, 0, 0, 0, T_NX);
      7'd64: r = mi(OP_MUL, T_H1, A_QZ, 0, 0, 0, T_NX);
      7'd65: r = mi(OP_MUL, T_H2, A_QY, 0, 1, 1, T_NX);
      7'd66: r = mi(OP_REG, A_QY, A_QY, 1, 0, 0, T_NY);
      7'd67: r = mi(OP_MUL, T_H0, A_QZ, 0, 1, 0, T_NY);
      7'd68: r = mi(OP_MUL, T_H1, A_QW, 0, 0, 0, T_NY);
      7'd69: r = mi(OP_MUL, T_H2, A_QX, 0, 0, 1, T_NY);
      7'd70: r = mi(OP_REG, A_QZ, A_QZ, 1, 0, 0, T_NZ);
      7'd71: r = mi(OP_MUL, T_H0, A_QY, 0, 0, 0, T_NZ);
      7'd72: r = mi(OP_MUL, T_H1, A_QX, 0, 1, 0, T_NZ);
      7'd73: r = mi(OP_MUL, T_H2, A_QW, 0, 0, 1, T_NZ);
      7'd74: r = mi(OP_REG, T_NW, T_NW, 1, 0, 1, A_QW);
      7'd75: r = mi(OP_REG, T_NX, T_NX, 1, 0, 1, A_QX);
      7'd76: r = mi(OP_REG, T_NY, T_NY, 1, 0, 1, A_QY);
      7'd77: r = mi(OP_REG, T_NZ, T_NZ, 1, 0, 1, A_QZ);
      default: r = '0;
    endcase
    return r;
  endfunction

  // scale by 2^-16 or 2^-17, round half up, saturate
  function automatic logic signed [DW-1:0] rnd_sat(logic signed [2*DW-1:0] p, logic h);
    logic signed [2*DW:0] t;
    logic signed [2*DW:0] s;
    t = {p[2*DW-1], p} + (h ? 65'sd65536 : 65'sd32768);
    s = h ? (t >>> (FB + 1)) : (t >>> FB);
    if (s > 65'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (s < -65'sh0_8000_0000) return 32'sh8000_0000;
    return s[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] sat_acc(logic signed [AW-1:0] v);
    if (v > 40'sh00_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -40'sh00_8000_0000) return 32'sh8000_0000;
    return v[DW-1:0];
  endfunction

endpackage

/* design/ssp_ctrl.sv */
// ----------------------------------------------------------------------------
// ssp_ctrl
// Sequencer: accepts an item, steps the microprogram, waits for the drain.
// ----------------------------------------------------------------------------
module ssp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          out_stall,
  input  ssp_pkg::sts_t sts,
  output logic          in_stall,
  output ssp_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [ssp_pkg::PW-1:0] pc_r, pc_nxt;
  logic                   drn_r, drn_nxt;
  logic                   acc_ok;

  assign acc_ok   = (state_r == S_IDLE) && (!sts.out_full || !out_stall);
  assign in_stall = !acc_ok;

  always_comb begin
    cmd.load = in_valid && acc_ok;
    cmd.ins  = ssp_pkg::prog(pc_r);
    if (state_r != S_RUN) begin
      cmd.ins.en = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    drn_nxt   = drn_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_RUN;
          pc_nxt    = '0;
        end
      end
      S_RUN: begin
        if (pc_r == ssp_pkg::PC_LAST) begin
          state_nxt = S_DRAIN;
          drn_nxt   = 1'b0;
        end else begin
          pc_nxt = pc_r + 7'd1;
        end
      end
      S_DRAIN: begin
        // stay until the last instruction has passed ins1_r and ins2_r and its write lands
        drn_nxt = 1'b1;
        if (drn_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      drn_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      drn_r   <= drn_nxt;
    end
  end

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_IDLE) else $error("item taken while busy");
  a_load_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_RUN && pc_r == '0)) else $error("run did not start");
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> pc_r <= ssp_pkg::PC_LAST) else $error("pc out of range");
  a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && pc_r == ssp_pkg::PC_LAST) |=> ##1 ##1 state_r == S_IDLE)
    else $error("drain length wrong");

endmodule

/* design/ssp_dpath.sv */
// ----------------------------------------------------------------------------
// ssp_dpath
// Shared multiplier, accumulator, scratch memory, state and output registers.
// ----------------------------------------------------------------------------
module ssp_dpath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ssp_pkg::cmd_t         cmd,
  output ssp_pkg::sts_t         sts,
  input  logic [15:0]           time_step,
  input  logic signed [31:0]    in_acc_x,
  input  logic signed [31:0]    in_acc_y,
  input  logic signed [31:0]    in_acc_z,
  input  logic signed [31:0]    in_rate_x,
  input  logic signed [31:0]    in_rate_y,
  input  logic signed [31:0]    in_rate_z,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic signed [31:0]    out_pos_x,
  output logic signed [31:0]    out_pos_y,
  output logic signed [31:0]    out_pos_z,
  output logic signed [31:0]    out_vel_x,
  output logic signed [31:0]    out_vel_y,
  output logic signed [31:0]    out_vel_z,
  output logic signed [31:0]    out_att_w,
  output logic signed [31:0]    out_att_x,
  output logic signed [31:0]    out_att_y,
  output logic signed [31:0]    out_att_z
);

  typedef logic signed [ssp_pkg::DW-1:0] word_t;

  word_t ax_r [3];
  word_t rx_r [3];
  word_t pos_r [3];
  word_t vel_r [3];
  word_t qw_r, qx_r, qy_r, qz_r;
  word_t mem [32];
  word_t opo [10];
  logic  out_valid_r;

  // stage 0 -> 1
  ssp_pkg::instr_t ins1_r, ins2_r;
  word_t mema_r, memb_r, nama_r, namb_r;
  word_t nama, namb, opa, opb;
  // stage 1 -> 2
  logic signed [2*ssp_pkg::DW-1:0] prod_r;
  logic signed [ssp_pkg::AW-1:0]   rterm_r;
  logic signed [ssp_pkg::AW-1:0]   acc_r, acc_nxt, term;
  word_t wdata;

  function automatic word_t named(logic [5:0] a, word_t ax [3], word_t rx [3],
                                  word_t ps [3], word_t vl [3], word_t w, word_t x,
                                  word_t y, word_t z, logic [15:0] dt);
    word_t r;
    case (a)
      ssp_pkg::A_AX0: r = ax[0];
      ssp_pkg::A_AX1: r = ax[1];
      ssp_pkg::A_AX2: r = ax[2];
      ssp_pkg::A_RX0: r = rx[0];
      ssp_pkg::A_RX1: r = rx[1];
      ssp_pkg::A_RX2: r = rx[2];
      ssp_pkg::A_DT:  r = word_t'({16'd0, dt});
      ssp_pkg::A_P0:  r = ps[0];
      ssp_pkg::A_P1:  r = ps[1];
      ssp_pkg::A_P2:  r = ps[2];
      ssp_pkg::A_V0:  r = vl[0];
      ssp_pkg::A_V1:  r = vl[1];
      ssp_pkg::A_V2:  r = vl[2];
      ssp_pkg::A_QW:  r = w;
      ssp_pkg::A_QX:  r = x;
      ssp_pkg::A_QY:  r = y;
      ssp_pkg::A_QZ:  r = z;
      ssp_pkg::A_ONE: r = ssp_pkg::ONE;
      default:        r = '0;
    endcase
    return r;
  endfunction

  assign nama = named(cmd.ins.a, ax_r, rx_r, pos_r, vel_r, qw_r, qx_r, qy_r, qz_r,
                      time_step);
  assign namb = named(cmd.ins.b, ax_r, rx_r, pos_r, vel_r, qw_r, qx_r, qy_r, qz_r,
                      time_step);

  always_ff @(posedge clk) begin
    mema_r <= mem[cmd.ins.a[4:0]];
    memb_r <= mem[cmd.ins.b[4:0]];
    nama_r <= nama;
    namb_r <= namb;
  end

  assign opa = ins1_r.a[5] ? mema_r : nama_r;
  assign opb = ins1_r.b[5] ? memb_r : namb_r;

  always_ff @(posedge clk) begin
    prod_r  <= opa * opb;
    rterm_r <= (ins1_r.op == ssp_pkg::OP_REG2) ?
               (ssp_pkg::AW'(opa) <<< 1) : ssp_pkg::AW'(opa);
  end

  always_comb begin
    case (ins2_r.op)
      ssp_pkg::OP_MUL:  term = ssp_pkg::AW'(ssp_pkg::rnd_sat(prod_r, 1'b0));
      ssp_pkg::OP_MULH: term = ssp_pkg::AW'(ssp_pkg::rnd_sat(prod_r, 1'b1));
      default:          term = rterm_r;
    endcase
    acc_nxt = (ins2_r.clr ? '0 : acc_r) + (ins2_r.neg ? -term : term);
    wdata   = ssp_pkg::sat_acc(acc_nxt);
  end

  always_ff @(posedge clk) begin
    if (ins2_r.en) begin
      acc_r <= acc_nxt;
    end
    if (ins2_r.en && ins2_r.wr && ins2_r.dst[5]) begin
      mem[ins2_r.dst[4:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ins1_r      <= '0;
      ins2_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
      end
      qw_r <= ssp_pkg::ONE;
      qx_r <= '0;
      qy_r <= '0;
      qz_r <= '0;
    end else begin
      ins1_r <= cmd.ins;
      ins2_r <= ins1_r;
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (ins2_r.en && ins2_r.wr && !ins2_r.dst[5]) begin
        case (ins2_r.dst)
          ssp_pkg::A_P0: pos_r[0] <= wdata;
          ssp_pkg::A_P1: pos_r[1] <= wdata;
          ssp_pkg::A_P2: pos_r[2] <= wdata;
          ssp_pkg::A_V0: vel_r[0] <= wdata;
          ssp_pkg::A_V1: vel_r[1] <= wdata;
          ssp_pkg::A_V2: vel_r[2] <= wdata;
          ssp_pkg::A_QW: qw_r     <= wdata;
          ssp_pkg::A_QX: qx_r     <= wdata;
          ssp_pkg::A_QY: qy_r     <= wdata;
          ssp_pkg::A_QZ: qz_r     <= wdata;
          default: ;
        endcase
      end
    end
  end

  // capture the item and the state it sees
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r[0] <= in_acc_x;  ax_r[1] <= in_acc_y;  ax_r[2] <= in_acc_z;
      rx_r[0] <= in_rate_x; rx_r[1] <= in_rate_y; rx_r[2] <= in_rate_z;
      opo[0] <= pos_r[0]; opo[1] <= pos_r[1]; opo[2] <= pos_r[2];
      opo[3] <= vel_r[0]; opo[4] <= vel_r[1]; opo[5] <= vel_r[2];
      opo[6] <= qw_r; opo[7] <= qx_r; opo[8] <= qy_r; opo[9] <= qz_r;
    end
  end

  assign sts.out_full = out_valid_r;
  assign out_valid = out_valid_r;
  assign out_pos_x = opo[0];
  assign out_pos_y = opo[1];
  assign out_pos_z = opo[2];
  assign out_vel_x = opo[3];
  assign out_vel_y = opo[4];
  assign out_vel_z = opo[5];
  assign out_att_w = opo[6];
  assign out_att_x = opo[7];
  assign out_att_y = opo[8];
  assign out_att_z = opo[9];

endmodule

/* design/strapdown_state_propagation.sv */
// latency: the result item (state before the sample) is valid the cycle after accept
// per item: the accept, 78 microprogram steps through the one shared 32x32 multiplier
//   and accumulator, and a pipeline drain; no new item is taken while busy
// reset: position and velocity zero, attitude the unit quaternion, time_step 655
// reset is synchronous, active low; the scratch memory needs no clearing
// ----------------------------------------------------------------------------
// strapdown_state_propagation
// Strapdown inertial propagation of position, velocity and attitude.
// ----------------------------------------------------------------------------
module strapdown_state_propagation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_acc_x,
  input  logic signed [31:0] in_acc_y,
  input  logic signed [31:0] in_acc_z,
  input  logic signed [31:0] in_rate_x,
  input  logic signed [31:0] in_rate_y,
  input  logic signed [31:0] in_rate_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic signed [31:0] out_vel_z,
  output logic signed [31:0] out_att_w,
  output logic signed [31:0] out_att_x,
  output logic signed [31:0] out_att_y,
  output logic signed [31:0] out_att_z
);

  localparam logic [2:0] REG_TIME_STEP = 3'd0;

  ssp_pkg::cmd_t cmd;
  ssp_pkg::sts_t sts;
  logic [15:0]   ts_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_TIME_STEP) ? {16'd0, ts_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= ssp_pkg::TS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_TIME_STEP) begin
      ts_r <= cfg_pwdata[15:0];
    end
  end

  ssp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  ssp_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .time_step (ts_r),
    .in_acc_x  (in_acc_x),
    .in_acc_y  (in_acc_y),
    .in_acc_z  (in_acc_z),
    .in_rate_x (in_rate_x),
    .in_rate_y (in_rate_y),
    .in_rate_z (in_rate_z),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_pos_x (out_pos_x),
    .out_pos_y (out_pos_y),
    .out_pos_z (out_pos_z),
    .out_vel_x (out_vel_x),
    .out_vel_y (out_vel_y),
    .out_vel_z (out_vel_z),
    .out_att_w (out_att_w),
    .out_att_x (out_att_x),
    .out_att_y (out_att_y),
    .out_att_z (out_att_z)
  );

endmodule
